// ===== rtl/core/encoder_speed_pid_pwm_assert.svh =====
// Assertion macros used by the checker of this block.
`ifndef ENCODER_SPEED_PID_PWM_ASSERT_SVH
`define ENCODER_SPEED_PID_PWM_ASSERT_SVH

// pre holds in a cycle -> post holds in the same cycle
`define ESP_ASSERT_IMP(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
    else $error("esp check failed");

// pre holds in a cycle -> post holds in the next cycle
`define ESP_ASSERT_NXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
    else $error("esp check failed");

`endif

// ===== rtl/core/esp_pkg.sv =====
package esp_pkg;

  localparam int FRACTION_BITS_DEF = 16;
  localparam int ACC_W             = 64;
  localparam int MUL_BITS          = 24;
  localparam int MUL_CNT_W         = $clog2(MUL_BITS + 1);
  localparam int CFG_IDX_W         = 4;
  localparam int CFG_DATA_W        = 24;

  localparam logic [19:0] SPEED_SCALE_RST    = 20'd27307;
  localparam logic [15:0] PERIOD_DT_RST      = 16'd3277;
  localparam logic [23:0] INVERSE_DT_RST     = 24'd1310720;
  localparam logic [19:0] GAIN_P_RST         = 20'd52429;
  localparam logic [19:0] GAIN_I_RST         = 20'd13107;
  localparam logic [19:0] GAIN_D_RST         = 20'd6554;
  localparam logic [22:0] INTEGRAL_LIMIT_RST = 23'd6553600;
  localparam logic [7:0]  PWM_LIMIT_RST      = 8'd255;
  localparam logic [31:0] COUNT_MID          = 32'h7FFF_FFFF;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SPEED_SCALE, REG_PERIOD_DT, REG_INVERSE_DT, REG_GAIN_P,
    REG_GAIN_I, REG_GAIN_D, REG_INTEGRAL_LIMIT, REG_PWM_LIMIT
  } cfg_reg_t;

  typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_DONE} state_t;

  typedef enum logic [2:0] {
    PH_SPEED, PH_INTEG, PH_DERIV, PH_PROP, PH_IGAIN, PH_DGAIN
  } phase_t;

  typedef struct packed {
    logic start;
    logic clear;
  } mul_ctrl_t;

endpackage

// ===== rtl/core/esp_if.sv =====
interface esp_in_if;
  logic               valid;
  logic               ready;
  logic [31:0]        encoder_count;
  logic signed [23:0] target_speed;
  logic               clear_integral;
  modport source(output valid, encoder_count, target_speed, clear_integral, input ready);
  modport sink(input valid, encoder_count, target_speed, clear_integral, output ready);
endinterface

interface esp_out_if;
  logic               valid;
  logic               ready;
  logic [7:0]         pwm_forward;
  logic [7:0]         pwm_reverse;
  logic signed [8:0]  drive_value;
  logic signed [23:0] measured_speed;
  logic signed [24:0] speed_error;
  modport source(output valid, pwm_forward, pwm_reverse, drive_value, measured_speed,
                 speed_error, input ready);
  modport sink(input valid, pwm_forward, pwm_reverse, drive_value, measured_speed,
               speed_error, output ready);
endinterface

interface esp_cfg_if;
  logic        valid;
  logic        ready;
  logic [3:0]  index;
  logic [23:0] data;
  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

// ===== rtl/core/esp_mul.sv =====
// Bit-serial shift-add multiplier: signed multiplicand, unsigned multiplier,
// one multiplier bit per cycle. Product accumulates unless clear is set at start.
module esp_mul (
  input  logic                             clk,
  input  logic                             rst,
  input  esp_pkg::mul_ctrl_t               ctrl,
  input  logic signed [esp_pkg::ACC_W-1:0] a_in,
  input  logic [esp_pkg::MUL_BITS-1:0]     b_in,
  output logic signed [esp_pkg::ACC_W-1:0] prod,
  output logic                             done
);
  import esp_pkg::*;

  logic [ACC_W-1:0]     a_sh;
  logic [MUL_BITS-1:0]  b_sh;
  logic [MUL_CNT_W-1:0] cnt;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= (cnt == MUL_CNT_W'(1));
      if (ctrl.start) begin
        a_sh <= a_in;
        b_sh <= b_in;
        cnt  <= MUL_CNT_W'(MUL_BITS);
        if (ctrl.clear) begin
          prod <= '0;
        end
      end else if (cnt != '0) begin
        if (b_sh[0]) begin
          prod <= prod + signed'(a_sh);
        end
        a_sh <= a_sh << 1;
        b_sh <= b_sh >> 1;
        cnt  <= cnt - MUL_CNT_W'(1);
      end
    end
  end

endmodule

// ===== rtl/core/encoder_speed_pid_pwm.sv =====
// channel   dir   word
// sample    in    encoder_count, target_speed, clear_integral
// result    out   pwm_forward, pwm_reverse, drive_value, measured_speed, speed_error
// cfg       in    index, data (ready whenever out of reset)
// One tick runs six serial multiplies on the shared bit-serial multiplier, each one
// a launch step, 24 shift-add steps and a step that takes the product.
// sample.ready returns in the same cycle that result.valid rises, so a new tick
// is taken only once the last one has reached the output register.
// A finished word waits in the output register; a stalled result holds the
// next tick only until that register frees. rst is synchronous and restores
// register defaults and the controller state.
module encoder_speed_pid_pwm #(
  parameter int FRACTION_BITS = esp_pkg::FRACTION_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  esp_in_if.sink   sample,
  esp_out_if.source result,
  esp_cfg_if.sink  cfg
);
  import esp_pkg::*;

  logic [19:0] speed_scale, gain_p, gain_i, gain_d;
  logic [15:0] period_dt;
  logic [23:0] inverse_dt;
  logic [22:0] integral_limit;
  logic [7:0]  pwm_limit;

  state_t state, state_next;
  phase_t phase;
  logic   launch;

  logic [31:0]        prev_count, delta;
  logic signed [23:0] target, integ, speed;
  logic signed [24:0] prev_err, err;
  logic               clr;
  logic signed [ACC_W-1:0] sum_now, diff;
  logic signed [8:0]  drive;

  mul_ctrl_t               mul_ctrl;
  logic signed [ACC_W-1:0] mul_a, mul_prod;
  logic [MUL_BITS-1:0]     mul_b;
  logic                    mul_done;

  logic accept, out_free;
  assign accept   = sample.valid && sample.ready;
  assign out_free = !result.valid || result.ready;
  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_scale    <= SPEED_SCALE_RST;
      period_dt      <= PERIOD_DT_RST;
      inverse_dt     <= INVERSE_DT_RST;
      gain_p         <= GAIN_P_RST;
      gain_i         <= GAIN_I_RST;
      gain_d         <= GAIN_D_RST;
      integral_limit <= INTEGRAL_LIMIT_RST;
      pwm_limit      <= PWM_LIMIT_RST;
    end else if (cfg.valid) begin
      unique case (cfg_reg_t'(cfg.index))
        REG_SPEED_SCALE:    speed_scale    <= cfg.data[19:0];
        REG_PERIOD_DT:      period_dt      <= cfg.data[15:0];
        REG_INVERSE_DT:     inverse_dt     <= cfg.data[23:0];
        REG_GAIN_P:         gain_p         <= cfg.data[19:0];
        REG_GAIN_I:         gain_i         <= cfg.data[19:0];
        REG_GAIN_D:         gain_d         <= cfg.data[19:0];
        REG_INTEGRAL_LIMIT: integral_limit <= cfg.data[22:0];
        REG_PWM_LIMIT:      pwm_limit      <= cfg.data[7:0];
        default: ;
      endcase
    end
  end

  // multiplier operands per phase
  logic signed [25:0] err_step;
  assign err_step = {err[24], err} - {prev_err[24], prev_err};

  always_comb begin
    unique case (phase)
      PH_SPEED: begin
        mul_a = {{(ACC_W-32){delta[31]}}, delta};
        mul_b = MUL_BITS'(speed_scale);
      end
      PH_INTEG: begin
        mul_a = {{(ACC_W-25){err[24]}}, err};
        mul_b = MUL_BITS'(period_dt);
      end
      PH_DERIV: begin
        mul_a = {{(ACC_W-26){err_step[25]}}, err_step};
        mul_b = MUL_BITS'(inverse_dt);
      end
      PH_PROP: begin
        mul_a = {{(ACC_W-25){err[24]}}, err};
        mul_b = MUL_BITS'(gain_p);
      end
      PH_IGAIN: begin
        mul_a = sum_now;
        mul_b = MUL_BITS'(gain_i);
      end
      PH_DGAIN: begin
        mul_a = diff;
        mul_b = MUL_BITS'(gain_d);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  esp_mul u_mul (
    .clk  (clk),
    .rst  (rst),
    .ctrl (mul_ctrl),
    .a_in (mul_a),
    .b_in (mul_b),
    .prod (mul_prod),
    .done (mul_done)
  );

  // post-processing of the finished product
  localparam logic signed [ACC_W-1:0] SPD_MAX = ACC_W'(64'sd8388607);
  localparam logic signed [ACC_W-1:0] SPD_MIN = -ACC_W'(64'sd8388608);

  logic signed [23:0]      speed_c;
  logic signed [ACC_W-1:0] prod_fl, lim_w, sum_cl;
  logic [ACC_W-1:0]        mag_abs, mag_sh;
  logic [7:0]              mag_sat;
  logic signed [8:0]       drive_c;

  always_comb begin
    priority if (mul_prod > SPD_MAX) speed_c = 24'sd8388607;
    else if (mul_prod < SPD_MIN)     speed_c = -24'sd8388608;
    else                             speed_c = mul_prod[23:0];

    prod_fl = mul_prod >>> FRACTION_BITS;

    mag_abs = mul_prod[ACC_W-1] ? ACC_W'(-mul_prod) : ACC_W'(mul_prod);
    mag_sh  = mag_abs >> (2 * FRACTION_BITS);
    mag_sat = (mag_sh > ACC_W'(pwm_limit)) ? pwm_limit : mag_sh[7:0];
    drive_c = mul_prod[ACC_W-1] ? -signed'({1'b0, mag_sat}) : signed'({1'b0, mag_sat});

    lim_w = signed'({{(ACC_W-23){1'b0}}, integral_limit});
    priority if (sum_now > lim_w) sum_cl = lim_w;
    else if (sum_now < -lim_w)    sum_cl = -lim_w;
    else                          sum_cl = sum_now;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: if (accept) state_next = ST_RUN;
      ST_RUN:  if (mul_done && phase == PH_DGAIN) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    sample.ready   = (state == ST_IDLE) && !rst;
    mul_ctrl.start = launch;
    mul_ctrl.clear = !(phase == PH_IGAIN || phase == PH_DGAIN);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      phase      <= PH_SPEED;
      launch     <= 1'b0;
      prev_count <= COUNT_MID;
      prev_err   <= '0;
      integ      <= '0;
    end else begin
      state  <= state_next;
      launch <= 1'b0;
      if (accept) begin
        delta      <= sample.encoder_count - prev_count;
        prev_count <= sample.encoder_count;
        target     <= sample.target_speed;
        clr        <= sample.clear_integral;
        phase      <= PH_SPEED;
        launch     <= 1'b1;
      end else if (state == ST_RUN && mul_done) begin
        unique case (phase)
          PH_SPEED: begin
            speed  <= speed_c;
            err    <= {target[23], target} - {speed_c[23], speed_c};
            phase  <= PH_INTEG;
            launch <= 1'b1;
          end
          PH_INTEG: begin
            sum_now <= {{(ACC_W-24){integ[23]}}, integ} + prod_fl;
            phase   <= PH_DERIV;
            launch  <= 1'b1;
          end
          PH_DERIV: begin
            diff     <= prod_fl;
            prev_err <= err;
            phase    <= PH_PROP;
            launch   <= 1'b1;
          end
          PH_PROP: begin
            phase  <= PH_IGAIN;
            launch <= 1'b1;
          end
          PH_IGAIN: begin
            phase  <= PH_DGAIN;
            launch <= 1'b1;
          end
          PH_DGAIN: begin
            drive <= drive_c;
            integ <= clr ? '0 : sum_cl[23:0];
          end
          default: phase <= PH_SPEED;
        endcase
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == ST_DONE && out_free) begin
      result.valid          <= 1'b1;
      result.drive_value    <= drive;
      result.pwm_forward    <= drive[8] ? 8'd0 : drive[7:0];
      result.pwm_reverse    <= drive[8] ? 8'(-drive) : 8'd0;
      result.measured_speed <= speed;
      result.speed_error    <= err;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

endmodule

// ===== rtl/core/esp_checker.sv =====
module esp_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [7:0]  out_fwd,
  input logic [7:0]  out_rev,
  input logic [8:0]  out_drive
);
`include "encoder_speed_pid_pwm_assert.svh"

  logic in_acc;
  assign in_acc = in_valid && in_ready;

  // a stalled result word holds its drive
`ESP_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_drive))
  // one tick at a time
`ESP_ASSERT_NXT(a_busy_after_accept, in_acc, !in_ready)
  // no result can appear right after a tick is taken
`ESP_ASSERT_NXT(a_no_early_result, in_acc, !$rose(out_valid))
  // never both motor pins driven
`ESP_ASSERT_IMP(a_one_side, out_valid, out_fwd == 8'd0 || out_rev == 8'd0)

endmodule

bind encoder_speed_pid_pwm esp_checker u_esp_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (sample.valid),
  .in_ready  (sample.ready),
  .out_valid (result.valid),
  .out_ready (result.ready),
  .out_fwd   (result.pwm_forward),
  .out_rev   (result.pwm_reverse),
  .out_drive (result.drive_value)
);
